[rtl/deq_pkg.sv]
// Shared widths and command codes for the double-ended queue.
package deq_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_SIZE       = 3'd6
    } t_cmd;

endpackage

[rtl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit words kept in a ring memory.
//
// Each command transfer on the slave side yields exactly one result transfer on the
// master side. Words can be pushed or popped at either end, peeked at either end, or
// the occupancy can be asked for. A pop or peek on an empty queue, or a push on a
// full queue (DEPTH words), answers ok = 0 and changes nothing. Pushes, size
// requests and failing commands need no read, so they can follow back to back. A
// successful pop or peek passes through S_READ, as the ring memory has a registered
// read port: the address goes out in the cycle the command is accepted and the word
// is captured into the result register in the next. The result register lets a new
// command be accepted in the same cycle that the previous result is taken. The ring
// memory needs no clearing after reset; only occupied slots are read.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command channel.
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [WORD_W-1:0]       i_s_tdata,   // [31:0] value
    input  logic [CMD_W-1:0]        i_s_tuser,   // [2:0] command
    // Result channel.
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [((WORD_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                    o_m_tdata,   // [31:0] word, then occupancy, zero pad
    output logic [0:0]              o_m_tuser    // [0] ok
);

    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OUT_W      = WORD_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Ring memory and its registered read port.
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_front, n_front;
    logic [AW-1:0]     r_back, n_back;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic signed [WORD_W-1:0] r_out_word, n_out_word;
    logic [CNT_W-1:0]  r_out_occ, n_out_occ;

    logic              w_s_fire;
    logic              w_m_fire;
    logic              w_empty;
    logic              w_full;
    logic [AW-1:0]     w_front_up, w_front_dn, w_back_up, w_back_dn;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    t_cmd              w_cmd;

    assign w_m_fire   = r_out_valid && i_m_tready;
    // A command is taken only when the result register is free by the next edge,
    // so a read result written from S_READ always finds room.
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == FULL_CNT);
    assign w_cmd   = t_cmd'(i_s_tuser);

    // Pointer steps wrap at DEPTH, which need not be a power of two.
    assign w_front_up = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign w_front_dn = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign w_back_up  = (r_back == LAST_IDX) ? '0 : r_back + AW'(1);
    assign w_back_dn  = (r_back == '0) ? LAST_IDX : r_back - AW'(1);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_out_valid = r_out_valid && !w_m_fire;
        n_out_ok    = r_out_ok;
        n_out_word  = r_out_word;
        n_out_occ   = r_out_occ;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_wr_addr   = r_back;
        w_rd_addr   = r_front;

        if (r_state == S_READ) begin
            // Only successful pops and peeks come here; the count is already final.
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_out_ok    = 1'b1;
            n_out_word  = r_rd_data;
            n_out_occ   = r_count;
        end else if (w_s_fire) begin
            // Default answer: failure with the current occupancy.
            n_out_valid = 1'b1;
            n_out_ok    = 1'b0;
            n_out_word  = '0;
            n_out_occ   = r_count;
            case (w_cmd)
                CMD_PUSH_FRONT: begin
                    if (!w_full) begin
                        w_mem_we  = 1'b1;
                        w_wr_addr = w_front_dn;
                        n_front   = w_front_dn;
                        n_count   = r_count + CNT_W'(1);
                        n_out_ok  = 1'b1;
                        n_out_occ = r_count + CNT_W'(1);
                    end
                end
                CMD_PUSH_BACK: begin
                    if (!w_full) begin
                        w_mem_we  = 1'b1;
                        w_wr_addr = r_back;
                        n_back    = w_back_up;
                        n_count   = r_count + CNT_W'(1);
                        n_out_ok  = 1'b1;
                        n_out_occ = r_count + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (!w_empty) begin
                        w_mem_re    = 1'b1;
                        w_rd_addr   = r_front;
                        n_front     = w_front_up;
                        n_count     = r_count - CNT_W'(1);
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                    end
                end
                CMD_POP_BACK: begin
                    if (!w_empty) begin
                        w_mem_re    = 1'b1;
                        w_rd_addr   = w_back_dn;
                        n_back      = w_back_dn;
                        n_count     = r_count - CNT_W'(1);
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                    end
                end
                CMD_PEEK_FRONT: begin
                    if (!w_empty) begin
                        w_mem_re    = 1'b1;
                        w_rd_addr   = r_front;
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                    end
                end
                CMD_PEEK_BACK: begin
                    if (!w_empty) begin
                        w_mem_re    = 1'b1;
                        w_rd_addr   = w_back_dn;
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                    end
                end
                CMD_SIZE: begin
                    n_out_ok = 1'b1;
                end
                default: begin
                    // The unused command code answers as a failure.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= i_s_tdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_ok   <= n_out_ok;
        r_out_word <= n_out_word;
        r_out_occ  <= n_out_occ;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_ok;
    assign o_m_tdata  = OUT_DATA_W'({r_out_occ, r_out_word});

    // The occupancy never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy above capacity");

    // An empty queue has both pointers on the same slot.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == r_back))
        else $error("pointers differ on an empty queue");

    // A push on a full queue leaves the pointers and count untouched.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && w_full && (w_cmd == CMD_PUSH_FRONT || w_cmd == CMD_PUSH_BACK))
        |=> ($stable(r_count) && $stable(r_front) && $stable(r_back)))
        else $error("push on a full queue changed state");

    // Read data always finds the result register free.
    a_read_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result register busy when read data arrived");

    // A failed result carries a zero word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_word == '0))
        else $error("failed result with a nonzero word");

endmodule

[tb/double_ended_queue_test.sv]
// Self-checking testbench for the double-ended queue with random command and result stalls.
`timescale 1ns / 1ps

module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int OCC_W      = 5;
    // The result word and the occupancy, padded with zeros to whole bytes.
    localparam int RES_DATA_W = 40;
    localparam int ITEM_COUNT = 1800;
    localparam int GAP_MAX    = 13;

    // The command code that the package leaves unused. The block must fail it and change nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // One expected result transfer.
    typedef struct {
        logic                     ok;
        logic signed [WORD_W-1:0] word;
        logic [OCC_W-1:0]         occupancy;
    } t_deq_result;

    // The mirror keeps its own copy of the ring and its indices. Each accepted
    // command updates that copy and queues the result the block should answer.
    // Results leave the block in command order, so every result is matched
    // against the oldest queued one.
    class deque_mirror;
        logic [WORD_W-1:0] ring[DEPTH];
        int unsigned       head_slot;
        int unsigned       tail_slot;
        int unsigned       word_count;
        t_deq_result       awaited_results[$];
        int unsigned       mismatch_count;

        function new();
            head_slot      = 0;
            tail_slot      = 0;
            word_count     = 0;
            mismatch_count = 0;
        endfunction

        // Apply one accepted command and record the result it must produce.
        function void take_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] value);
            t_deq_result res;
            res.ok   = 1'b0;
            res.word = '0;
            case (cmd)
                CMD_PUSH_FRONT: begin
                    if (word_count < DEPTH) begin
                        head_slot       = (head_slot + DEPTH - 1) % DEPTH;
                        ring[head_slot] = value;
                        word_count++;
                        res.ok = 1'b1;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (word_count < DEPTH) begin
                        ring[tail_slot] = value;
                        tail_slot       = (tail_slot + 1) % DEPTH;
                        word_count++;
                        res.ok = 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    if (word_count != 0) begin
                        res.word  = ring[head_slot];
                        head_slot = (head_slot + 1) % DEPTH;
                        word_count--;
                        res.ok = 1'b1;
                    end
                end
                CMD_POP_BACK: begin
                    if (word_count != 0) begin
                        tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
                        res.word  = ring[tail_slot];
                        word_count--;
                        res.ok = 1'b1;
                    end
                end
                CMD_PEEK_FRONT: begin
                    if (word_count != 0) begin
                        res.word = ring[head_slot];
                        res.ok   = 1'b1;
                    end
                end
                CMD_PEEK_BACK: begin
                    if (word_count != 0) begin
                        res.word = ring[(tail_slot + DEPTH - 1) % DEPTH];
                        res.ok   = 1'b1;
                    end
                end
                CMD_SIZE: begin
                    res.ok = 1'b1;
                end
                default: begin
                    // The unused code changes nothing and fails.
                end
            endcase
            res.occupancy = word_count[OCC_W-1:0];
            awaited_results.push_back(res);
        endfunction

        // Compare one result transfer with the oldest awaited result.
        function void match_result(logic ok, logic signed [WORD_W-1:0] word,
                                   logic [OCC_W-1:0] occupancy);
            t_deq_result res;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with none awaited: ok=%0b word=%0d occ=%0d",
                             $realtime, ok, word, occupancy);
            end else begin
                res = awaited_results.pop_front();
                if (ok !== res.ok || word !== res.word || occupancy !== res.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: result mismatch: expected ok=%0b word=%0d occ=%0d,",
                                  " got ok=%0b word=%0d occ=%0d"},
                                 $realtime, res.ok, res.word, res.occupancy,
                                 ok, word, occupancy);
                end
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    // All block inputs start at known values; reset is held low from time zero.
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [WORD_W-1:0]       i_s_tdata  = '0;   // [31:0] value
    logic [CMD_W-1:0]        i_s_tuser  = '0;   // [2:0] command
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [RES_DATA_W-1:0]   o_m_tdata;         // [31:0] word, [36:32] occupancy, zero pad
    logic [0:0]              o_m_tuser;         // [0] ok

    // While a side runs calm, it draws no idle cycles, so stretches without
    // stalls alternate with stretches full of them.
    bit          sender_calm   = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned sent_count    = 0;

    deque_mirror mirror = new();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Offer one command after a random number of idle cycles and hold it until
    // the block takes it. The task is entered at a rising edge and returns at
    // the edge of the transfer, so tvalid gets one assignment per edge and
    // stays high between back-to-back commands.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] value);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        mirror.take_command(cmd, value);
        sent_count++;
    endtask

    // A value that hits the extremes often and otherwise sets random bits.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Stall the pipeline input until every awaited result has been taken.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (mirror.pending() != 0);
    endtask

    // Random stimulus in bursts. Each burst leans toward filling, draining or
    // mixing, so the queue keeps reaching both full and empty with random
    // content, and pushes at the full limit and pops at empty both occur.
    task automatic random_bursts();
        int unsigned lean;
        int unsigned burst_len;
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned peek_pct;
        logic [CMD_W-1:0] cmd;
        bit paused;
        paused = 1'b0;
        while (sent_count < ITEM_COUNT) begin
            lean          = $urandom_range(0, 2);
            burst_len     = $urandom_range(10, 60);
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            case (lean)
                0:       begin push_pct = 70; pop_pct = 15; peek_pct = 10; end
                1:       begin push_pct = 20; pop_pct = 50; peek_pct = 20; end
                default: begin push_pct = 40; pop_pct = 30; peek_pct = 20; end
            endcase
            repeat (burst_len) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else if (roll < push_pct + pop_pct)
                    cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                else if (roll < push_pct + pop_pct + peek_pct)
                    cmd = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
                else if (roll < 97)
                    cmd = CMD_SIZE;
                else
                    cmd = CMD_UNUSED;
                send_command(cmd, pick_value());
            end
            // Once, midway, let the block run completely dry before going on.
            if (!paused && sent_count >= ITEM_COUNT / 2) begin
                paused = 1'b1;
                drain_results();
            end
        end
    endtask

    // Result side: take each result after a random stall and check it.
    initial begin : result_sink
        int unsigned gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = receiver_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            mirror.match_result(o_m_tuser[0], o_m_tdata[WORD_W-1:0],
                                o_m_tdata[WORD_W +: OCC_W]);
        end
    end

    // Command side: reset, directed commands, random bursts, then the wind-down.
    initial begin : command_source
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Everything on an empty queue fails except size, and
        // the unused code fails as well.
        sender_calm = 1'b0;
        send_command(CMD_PEEK_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_PEEK_BACK,  32'h8000_0000);
        send_command(CMD_POP_FRONT,  32'h7FFF_FFFF);
        send_command(CMD_POP_BACK,   32'h0000_0000);
        send_command(CMD_SIZE,       32'hFFFF_FFFF);
        send_command(CMD_UNUSED,     32'hFFFF_FFFF);
        // Extreme words at both ends, then read them back from both ends.
        send_command(CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(CMD_PUSH_BACK,  32'h7FFF_FFFF);
        send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_PUSH_BACK,  32'h0000_0000);
        send_command(CMD_UNUSED,     32'h5A5A_A5A5);
        send_command(CMD_SIZE,       32'h0000_0000);
        send_command(CMD_PEEK_FRONT, 32'h1234_5678);
        send_command(CMD_PEEK_BACK,  32'h8765_4321);
        // Back-to-back pops and peeks with no idle cycles on either side.
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        send_command(CMD_POP_FRONT,  32'h0000_0000);
        send_command(CMD_POP_BACK,   32'h0000_0000);
        send_command(CMD_PEEK_FRONT, 32'h0000_0000);
        send_command(CMD_POP_BACK,   32'h0000_0000);
        send_command(CMD_POP_FRONT,  32'h0000_0000);
        // Now empty again: the pop and peek after the last word fail.
        send_command(CMD_POP_FRONT,  32'h0000_0000);
        send_command(CMD_PEEK_BACK,  32'h0000_0000);
        send_command(CMD_PUSH_BACK,  32'h0F0F_F0F0);
        send_command(CMD_POP_FRONT,  32'h0000_0000);
        receiver_calm = 1'b0;
        sender_calm   = 1'b0;

        random_bursts();

        // Wait out every awaited result, then wait longer so that any stray result
        // would still be caught.
        i_s_tvalid <= 1'b0;
        receiver_calm = 1'b1;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mirror.mismatch_count == 0 && mirror.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
